// ----- design/ipdfp_pkg.sv -----
// ----------------------------------------------------------------------------
// ipdfp_pkg
// Shared constants for the +IPD frame parser: header characters, stage codes
// and field widths.
// ----------------------------------------------------------------------------
package ipdfp_pkg;

    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 16;
    localparam int STAGE_W = 3;
    localparam int MUL_W   = LEN_W + 4;

    localparam logic [BYTE_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [BYTE_W-1:0] CHAR_I     = 8'h49;
    localparam logic [BYTE_W-1:0] CHAR_P     = 8'h50;
    localparam logic [BYTE_W-1:0] CHAR_D     = 8'h44;
    localparam logic [BYTE_W-1:0] CHAR_COMMA = 8'h2C;
    localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;

    localparam logic [LEN_W-1:0] LEN_MAX = '1;

    localparam logic [STAGE_W-1:0] STAGE_HUNT    = 3'd0;
    localparam logic [STAGE_W-1:0] STAGE_I       = 3'd1;
    localparam logic [STAGE_W-1:0] STAGE_P       = 3'd2;
    localparam logic [STAGE_W-1:0] STAGE_D       = 3'd3;
    localparam logic [STAGE_W-1:0] STAGE_COMMA   = 3'd4;
    localparam logic [STAGE_W-1:0] STAGE_LENGTH  = 3'd5;
    localparam logic [STAGE_W-1:0] STAGE_PAYLOAD = 3'd6;

endpackage

// ----- design/ipd_frame_parser_core.sv -----
// ----------------------------------------------------------------------------
// ipd_frame_parser_core
// Hunts for the "+IPD," header in a byte stream, reads the decimal length and
// forwards exactly that many payload bytes with their index and a last flag.
//
// channel   dir  tdata (low bit up)                       tlast
// s_        in   rx_byte[7:0]                             -
// m_        out  payload_byte[7:0], payload_index[23:8]   last_byte
//
// one byte per cycle sustained while the m_ side accepts; a byte passes the
// input register, then the parser state update into the output register
// the parser state machine is updated only when the output register can
// take a new value, so a stalled m_ side holds one result and one byte
// aresetn is synchronous and clears valid flags and parser state
// ----------------------------------------------------------------------------
module ipd_frame_parser_core
    import ipdfp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // payload_byte, payload_index
    output logic        m_tlast    // last_byte
);

    logic               in_valid_reg;
    logic [BYTE_W-1:0]  in_byte_reg;

    logic [STAGE_W-1:0] stage_reg, stage_next;
    logic [LEN_W-1:0]   remain_reg, remain_next;
    logic [LEN_W-1:0]   pos_reg, pos_next;

    logic               out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]  out_byte_reg;
    logic [LEN_W-1:0]   out_index_reg;
    logic               out_last_reg;

    logic               advance;
    logic               process;
    logic               produce;
    logic               is_digit;
    logic [MUL_W-1:0]   len_mul;
    logic [LEN_W-1:0]   remain_dec;
    logic [BYTE_W-1:0]  expect_char;

    assign advance  = !out_valid_reg || m_tready;
    assign process  = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    assign is_digit   = (in_byte_reg >= CHAR_ZERO) && (in_byte_reg <= CHAR_NINE);
    assign len_mul    = {1'b0, remain_reg, 3'b000} + {3'b000, remain_reg, 1'b0}
                      + {{(MUL_W-BYTE_W){1'b0}}, in_byte_reg - CHAR_ZERO};
    assign remain_dec = remain_reg - {{(LEN_W-1){1'b0}}, 1'b1};

    always_comb begin
        case (stage_reg)
            STAGE_I:     expect_char = CHAR_I;
            STAGE_P:     expect_char = CHAR_P;
            STAGE_D:     expect_char = CHAR_D;
            STAGE_COMMA: expect_char = CHAR_COMMA;
            default:     expect_char = CHAR_PLUS;
        endcase
    end

    always_comb begin
        stage_next  = stage_reg;
        remain_next = remain_reg;
        pos_next    = pos_reg;
        produce     = 1'b0;
        case (stage_reg)
            STAGE_HUNT: begin
                if (in_byte_reg == CHAR_PLUS) begin
                    stage_next = STAGE_I;
                end
            end
            STAGE_I, STAGE_P, STAGE_D, STAGE_COMMA: begin
                if (in_byte_reg == expect_char) begin
                    stage_next = stage_reg + 3'd1;
                end else if (in_byte_reg == CHAR_PLUS) begin
                    stage_next = STAGE_I;
                end else begin
                    stage_next = STAGE_HUNT;
                end
            end
            STAGE_LENGTH: begin
                if (is_digit) begin
                    if (len_mul[MUL_W-1:LEN_W] != '0) begin
                        remain_next = LEN_MAX;
                    end else begin
                        remain_next = len_mul[LEN_W-1:0];
                    end
                end else if (remain_reg != '0) begin
                    pos_next   = '0;
                    stage_next = STAGE_PAYLOAD;
                end else begin
                    stage_next = STAGE_HUNT;
                end
            end
            STAGE_PAYLOAD: begin
                if (remain_reg != '0) begin
                    produce     = 1'b1;
                    remain_next = remain_dec;
                    pos_next    = pos_reg + {{(LEN_W-1){1'b0}}, 1'b1};
                    if (remain_dec == '0) begin
                        stage_next = STAGE_HUNT;
                    end
                end else begin
                    stage_next = STAGE_HUNT;
                end
            end
            default: begin
                stage_next = STAGE_HUNT;
            end
        endcase
    end

    always_comb begin
        if (advance) begin
            out_valid_next = process && produce;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            stage_reg     <= STAGE_HUNT;
            remain_reg    <= '0;
            pos_reg       <= '0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            out_valid_reg <= out_valid_next;
            if (process) begin
                stage_reg  <= stage_next;
                remain_reg <= remain_next;
                pos_reg    <= pos_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
        if (process && produce) begin
            out_byte_reg  <= in_byte_reg;
            out_index_reg <= pos_reg;
            out_last_reg  <= (remain_dec == '0);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_index_reg, out_byte_reg};
    assign m_tlast  = out_last_reg;

    // payload stage always has bytes left to send
    assert property (@(posedge aclk) disable iff (!aresetn)
        (stage_reg == STAGE_PAYLOAD) |-> (remain_reg != '0))
        else $error("payload stage with zero remaining length");

    // a pending last byte leaves the parser hunting
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (stage_reg == STAGE_HUNT))
        else $error("parser not hunting after last byte");

    // a pending non-last byte keeps the parser in payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> (stage_reg == STAGE_PAYLOAD))
        else $error("parser left payload before last byte");

    // next index follows the pending transaction
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (pos_reg == out_index_reg + {{(LEN_W-1){1'b0}}, 1'b1}))
        else $error("payload index out of step");

endmodule
